FILE: hdl/tcot_pkg.sv
// Shared types and constants for the circle/triangle overlap test.
// No dependencies; every other file in hdl/ imports this package.
package tcot_pkg;

  // Coordinate width, Q12.4 two's complement
  localparam int CB = 16;
  // Coordinate difference, product, sum of two products
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  // Radius and squared radius
  localparam int RW = CB - 1;
  localparam int R2W = 2 * RW;
  // Squared cross product and radius-scaled edge length
  localparam int QW = 2 * SW;
  // Pipeline depth from accept to result register
  localparam int DEPTH = 7;

  typedef enum logic [2:0] {
    REG_APEX_X     = 3'd0,
    REG_APEX_Y     = 3'd1,
    REG_CORNER_A_X = 3'd2,
    REG_CORNER_A_Y = 3'd3,
    REG_CORNER_B_X = 3'd4,
    REG_CORNER_B_Y = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    HIT_NONE   = 2'd0,
    HIT_CORNER = 2'd1,
    HIT_INSIDE = 2'd2,
    HIT_EDGE   = 2'd3
  } hit_t;

  typedef struct packed {
    logic signed [CB-1:0] center_x;
    logic signed [CB-1:0] center_y;
    logic        [RW-1:0] circle_radius;
  } in_item_t;

  typedef struct packed {
    logic       overlaps;
    logic [1:0] hit_case;
  } out_item_t;

endpackage

FILE: hdl/tcot_edge.sv
// Six-stage edge proximity test for one triangle edge.
// Depends on tcot_pkg.
module tcot_edge (
  input  logic                          clk,
  input  logic signed [tcot_pkg::CB-1:0] e0_x,
  input  logic signed [tcot_pkg::CB-1:0] e0_y,
  input  logic signed [tcot_pkg::CB-1:0] e1_x,
  input  logic signed [tcot_pkg::CB-1:0] e1_y,
  input  logic signed [tcot_pkg::CB-1:0] p_x,
  input  logic signed [tcot_pkg::CB-1:0] p_y,
  input  logic        [tcot_pkg::R2W-1:0] r2,
  output logic                          near
);
  import tcot_pkg::*;

  logic signed [DW-1:0] dx, dy, qx, qy;
  logic signed [PW-1:0] p_qxdx, p_qydy, p_dxdx, p_dydy, p_qxdy, p_qydx;
  logic signed [SW-1:0] len2, dt, cr;
  logic        [SW-1:0] mag, len2_d;
  logic                 onseg, onseg_e;
  logic        [QW-1:0] lhs, rhs;
  logic      [R2W-1:0] r2_b, r2_c, r2_d;

  // Stage A: edge vector and offset of the center from the edge start
  always_ff @(posedge clk) begin
    dx <= {e1_x[CB-1], e1_x} - {e0_x[CB-1], e0_x};
    dy <= {e1_y[CB-1], e1_y} - {e0_y[CB-1], e0_y};
    qx <= {p_x[CB-1], p_x} - {e0_x[CB-1], e0_x};
    qy <= {p_y[CB-1], p_y} - {e0_y[CB-1], e0_y};
    r2_b <= r2;
  end

  // Stage B: partial products
  always_ff @(posedge clk) begin
    p_qxdx <= qx * dx;
    p_qydy <= qy * dy;
    p_dxdx <= dx * dx;
    p_dydy <= dy * dy;
    p_qxdy <= qx * dy;
    p_qydx <= qy * dx;
    r2_c   <= r2_b;
  end

  // Stage C: dot products and cross product
  always_ff @(posedge clk) begin
    len2 <= SW'(p_dxdx) + SW'(p_dydy);
    dt   <= SW'(p_qxdx) + SW'(p_qydy);
    cr   <= SW'(p_qxdy) - SW'(p_qydx);
    r2_d <= r2_c;
  end

  // Stage D: projection on segment, cross magnitude
  always_ff @(posedge clk) begin
    onseg  <= (len2 != '0) && !dt[SW-1] && (dt <= len2);
    mag    <= cr[SW-1] ? SW'(-cr) : SW'(cr);
    len2_d <= SW'(len2);
  end

  // Stage E: squared distance against scaled radius
  always_ff @(posedge clk) begin
    lhs     <= QW'(mag) * QW'(mag);
    rhs     <= QW'(r2_d) * QW'(len2_d);
    onseg_e <= onseg;
  end

  // Stage F: verdict
  always_ff @(posedge clk) begin
    near <= onseg_e && (lhs <= rhs);
  end

`ifndef SYNTHESIS
  a_near_needs_seg: assert property (@(posedge clk) near |-> $past(onseg_e))
    else $error("edge hit without on-segment projection");
`endif

endmodule

FILE: hdl/triangle_circle_overlap_test.sv
// Top level of the circle/triangle overlap test: registers and pipeline.
// Depends on tcot_pkg and tcot_edge.
//
// One circle is accepted per clock whenever start is high (busy is always
// low), and its answer appears on result with a one-cycle done strobe; the
// receiver cannot stall, so results must be taken when shown. The depth of
// the pipeline is set by the edge test: differences, products, sums,
// magnitude, a 35x35 squaring and the final compare, each in a stage of its
// own. Triangle corners must be written through the cfg channel (always
// ready) only while no item is in flight; the block does not enforce this.
module triangle_circle_overlap_test (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  tcot_pkg::in_item_t        item_in,
  output logic                      done,
  output tcot_pkg::out_item_t       result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [tcot_pkg::CB-1:0]   cfg_data
);
  import tcot_pkg::*;

  logic signed [CB-1:0] apex_x, apex_y, corner_a_x, corner_a_y, corner_b_x, corner_b_y;
  logic [DEPTH:1]       vld;
  logic signed [CB-1:0] px, py;
  logic [RW-1:0]        rad;
  logic [R2W-1:0]       r2, r2_3, r2_4;
  logic signed [DW-1:0] ox_d, oy_d, ax_d, ay_d, bx_d, by_d;
  logic signed [DW-1:0] v0x, v0y, v1x, v1y, v2x, v2y;
  logic signed [PW-1:0] sq_ox, sq_oy, sq_ax, sq_ay, sq_bx, sq_by;
  logic signed [PW-1:0] c_a, c_b, nv_a, nv_b, nw_a, nw_b;
  logic [SW-1:0]        d2_o, d2_a, d2_b;
  logic signed [SW-1:0] c, nv, nw;
  logic signed [SW:0]   cn, nvn, nwn;
  logic signed [SW+1:0] vw_sum;
  logic                 corner5, inside5, corner6, inside6, corner7, inside7;
  logic                 near_ob, near_ba, near_ao;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Corner registers
  always_ff @(posedge clk) begin
    if (rst) begin
      apex_x <= '0; apex_y <= '0;
      corner_a_x <= '0; corner_a_y <= '0;
      corner_b_x <= '0; corner_b_y <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_APEX_X:     apex_x     <= cfg_data;
        REG_APEX_Y:     apex_y     <= cfg_data;
        REG_CORNER_A_X: corner_a_x <= cfg_data;
        REG_CORNER_A_Y: corner_a_y <= cfg_data;
        REG_CORNER_B_X: corner_b_x <= cfg_data;
        REG_CORNER_B_Y: corner_b_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the item, one per register stage up to the result
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[DEPTH-1:1], start};
      done <= vld[DEPTH];
    end
  end

  // Stage 1: capture item
  always_ff @(posedge clk) begin
    px  <= item_in.center_x;
    py  <= item_in.center_y;
    rad <= item_in.circle_radius;
  end

  // Stage 2: differences and squared radius
  always_ff @(posedge clk) begin
    r2   <= R2W'(rad) * R2W'(rad);
    ox_d <= {apex_x[CB-1], apex_x} - {px[CB-1], px};
    oy_d <= {apex_y[CB-1], apex_y} - {py[CB-1], py};
    ax_d <= {corner_a_x[CB-1], corner_a_x} - {px[CB-1], px};
    ay_d <= {corner_a_y[CB-1], corner_a_y} - {py[CB-1], py};
    bx_d <= {corner_b_x[CB-1], corner_b_x} - {px[CB-1], px};
    by_d <= {corner_b_y[CB-1], corner_b_y} - {py[CB-1], py};
    v0x  <= {corner_b_x[CB-1], corner_b_x} - {apex_x[CB-1], apex_x};
    v0y  <= {corner_b_y[CB-1], corner_b_y} - {apex_y[CB-1], apex_y};
    v1x  <= {corner_a_x[CB-1], corner_a_x} - {apex_x[CB-1], apex_x};
    v1y  <= {corner_a_y[CB-1], corner_a_y} - {apex_y[CB-1], apex_y};
    v2x  <= {px[CB-1], px} - {apex_x[CB-1], apex_x};
    v2y  <= {py[CB-1], py} - {apex_y[CB-1], apex_y};
  end

  // Stage 3: products
  always_ff @(posedge clk) begin
    sq_ox <= ox_d * ox_d;
    sq_oy <= oy_d * oy_d;
    sq_ax <= ax_d * ax_d;
    sq_ay <= ay_d * ay_d;
    sq_bx <= bx_d * bx_d;
    sq_by <= by_d * by_d;
    c_a   <= v0x * v1y;
    c_b   <= v0y * v1x;
    nv_a  <= v2x * v1y;
    nv_b  <= v2y * v1x;
    nw_a  <= v0x * v2y;
    nw_b  <= v0y * v2x;
    r2_3  <= r2;
  end

  // Stage 4: sums
  always_ff @(posedge clk) begin
    d2_o <= SW'(sq_ox) + SW'(sq_oy);
    d2_a <= SW'(sq_ax) + SW'(sq_ay);
    d2_b <= SW'(sq_bx) + SW'(sq_by);
    c    <= SW'(c_a) - SW'(c_b);
    nv   <= SW'(nv_a) - SW'(nv_b);
    nw   <= SW'(nw_a) - SW'(nw_b);
    r2_4 <= r2_3;
  end

  // Barycentric test with signs normalised to a positive denominator
  always_comb begin
    cn     = c[SW-1] ? -(SW+1)'(c)  : (SW+1)'(c);
    nvn    = c[SW-1] ? -(SW+1)'(nv) : (SW+1)'(nv);
    nwn    = c[SW-1] ? -(SW+1)'(nw) : (SW+1)'(nw);
    vw_sum = (SW+2)'(nvn) + (SW+2)'(nwn);
  end

  // Stage 5: corner and inside verdicts
  always_ff @(posedge clk) begin
    corner5 <= (d2_o <= SW'(r2_4)) || (d2_a <= SW'(r2_4)) || (d2_b <= SW'(r2_4));
    inside5 <= (cn != '0) && !nvn[SW] && !nwn[SW] && (vw_sum <= (SW+2)'(cn));
  end

  // Stages 6 and 7: wait for the edge tests
  always_ff @(posedge clk) begin
    corner6 <= corner5;
    inside6 <= inside5;
    corner7 <= corner6;
    inside7 <= inside6;
  end

  // Edges OB, BA, AO
  tcot_edge u_edge_ob (
    .clk (clk), .e0_x (apex_x), .e0_y (apex_y), .e1_x (corner_b_x), .e1_y (corner_b_y),
    .p_x (px), .p_y (py), .r2 (r2), .near (near_ob)
  );
  tcot_edge u_edge_ba (
    .clk (clk), .e0_x (corner_b_x), .e0_y (corner_b_y), .e1_x (corner_a_x),
    .e1_y (corner_a_y), .p_x (px), .p_y (py), .r2 (r2), .near (near_ba)
  );
  tcot_edge u_edge_ao (
    .clk (clk), .e0_x (corner_a_x), .e0_y (corner_a_y), .e1_x (apex_x), .e1_y (apex_y),
    .p_x (px), .p_y (py), .r2 (r2), .near (near_ao)
  );

  // Result register: first test that succeeds wins
  always_ff @(posedge clk) begin
    if (corner7) begin
      result.hit_case <= HIT_CORNER;
      result.overlaps <= 1'b1;
    end else if (inside7) begin
      result.hit_case <= HIT_INSIDE;
      result.overlaps <= 1'b1;
    end else if (near_ob || near_ba || near_ao) begin
      result.hit_case <= HIT_EDGE;
      result.overlaps <= 1'b1;
    end else begin
      result.hit_case <= HIT_NONE;
      result.overlaps <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
      done |-> $past(start, DEPTH + 1))
    else $error("result without a matching item");
  a_overlap_code: assert property (@(posedge clk) disable iff (rst)
      done |-> (result.overlaps == (result.hit_case != HIT_NONE)))
    else $error("overlap flag disagrees with hit code");
`endif

endmodule
